// File: hdl/bpa_pkg.sv
package bpa_pkg;

   localparam int NumPages  = 1024;
   localparam int MaxOrder  = 10;
   localparam int PageBits  = 12;
   localparam int PageIdxW  = 10;
   localparam int OrderW    = 4;
   localparam int CountW    = 11;
   localparam int AddrW     = 22;
   localparam int SizeW     = 23;

   // table entry: used flag, order+1 (0 means not a head)
   typedef struct packed {
      logic       used;
      logic [3:0] ordp1;
   } entry_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SIZE = 2'd1,
      ST_NO_BLOCK = 2'd2,
      ST_BAD_FREE = 2'd3
   } status_type;

   typedef struct packed {
      logic                    mode;
      logic [SizeW-1:0]        size_bytes;
      logic [AddrW-1:0]        free_address;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic [AddrW-1:0]        block_address;
      logic [OrderW-1:0]       block_order;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ASCAN,
      S_AREAD,
      S_ACHECK,
      S_ASPLIT,
      S_FREAD,
      S_FCHECK,
      S_BREAD,
      S_BCHECK,
      S_DONE
   } state_type;

endpackage

// File: hdl/buddy_page_allocator.sv
// Channel   Direction  Ports                      Beat
// request   in         start, busy, req_data      start & !busy
// response  out        rsp_strobe, rsp_data       rsp_strobe (one cycle)
//
// After reset a clearing pass writes all 1024 table entries, one a cycle with
// busy high, then page 0 holds a free head of the top order.
// Allocate scans the table entries in order (up to 1024) for a free head of the
// chosen order, then splits it one level at a time through the table write port.
// Free: head read, then buddy read and check per merge level, up to MaxOrder levels.
// The receiver cannot stall: every response is shown for one cycle.
module buddy_page_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bpa_pkg::req_type req_data,
   output logic             rsp_strobe,
   output bpa_pkg::rsp_type rsp_data
);

   bpa_pkg::state_type state_ff, state_in;
   logic [9:0]  ptr_ff, ptr_in;         // page pointer / clear counter
   logic [3:0]  want_ff, want_in;
   logic [3:0]  ord_ff, ord_in;
   logic [3:0]  k_ff, k_in;
   logic [9:0]  page_ff, page_in;
   logic [10:0] cnt_ff [0:10];
   logic [1:0]  stat_ff, stat_in;
   logic        strobe_ff;
   bpa_pkg::rsp_type rsp_ff;

   // table memory, one write port and one registered read port
   bpa_pkg::entry_type mem [0:1023];
   bpa_pkg::entry_type rd_ff;
   logic        we;
   logic [9:0]  waddr, raddr;
   bpa_pkg::entry_type wdata;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   // allocate front end: size check and rounding
   logic [10:0] pages;
   logic [3:0]  want_c;
   logic        big;
   always_comb begin
      pages  = req_data.size_bytes[22:12];
      want_c = 4'd0;
      big    = 1'b0;
      if (pages > 11'd1024) big = 1'b1;
      else begin
         for (int i = 10; i >= 0; i--)
            if (pages <= (11'd1 << i)) want_c = 4'(i);
      end
   end

   // lowest order with a free block at or above want
   logic [3:0] kfind;
   logic       kok;
   always_comb begin
      kfind = 4'd0;
      kok   = 1'b0;
      for (int i = 10; i >= 0; i--)
         if (4'(i) >= want_ff && cnt_ff[i] != 11'd0) begin
            kfind = 4'(i);
            kok   = 1'b1;
         end
   end

   logic [9:0] bud;
   assign bud = page_ff ^ (10'd1 << ord_ff);

   logic        cnt_dec, cnt_inc;
   logic [3:0]  cnt_dsel, cnt_isel;

   always_comb begin
      state_in = state_ff;
      ptr_in   = ptr_ff;
      want_in  = want_ff;
      ord_in   = ord_ff;
      k_in     = k_ff;
      page_in  = page_ff;
      stat_in  = stat_ff;
      we       = 1'b0;
      waddr    = ptr_ff;
      wdata    = '0;
      raddr    = ptr_ff;
      cnt_dec  = 1'b0;
      cnt_inc  = 1'b0;
      cnt_dsel = '0;
      cnt_isel = '0;
      unique case (state_ff)
         bpa_pkg::S_CLEAR: begin
            we    = 1'b1;
            if (ptr_ff == 10'd0) wdata = '{used: 1'b0, ordp1: 4'd11};
            ptr_in = ptr_ff + 10'd1;
            if (ptr_ff == 10'd1023) state_in = bpa_pkg::S_IDLE;
         end
         bpa_pkg::S_IDLE: begin
            if (start) begin
               if (req_data.mode) begin
                  page_in  = req_data.free_address[21:12];
                  state_in = bpa_pkg::S_FREAD;
               end else if (req_data.size_bytes[11:0] != 12'd0) begin
                  stat_in  = bpa_pkg::ST_BAD_SIZE;
                  state_in = bpa_pkg::S_DONE;
               end else if (big) begin
                  stat_in  = bpa_pkg::ST_NO_BLOCK;
                  state_in = bpa_pkg::S_DONE;
               end else begin
                  want_in  = want_c;
                  state_in = bpa_pkg::S_ASCAN;
               end
            end
         end
         bpa_pkg::S_ASCAN: begin
            if (!kok) begin
               stat_in  = bpa_pkg::ST_NO_BLOCK;
               state_in = bpa_pkg::S_DONE;
            end else begin
               k_in     = kfind;
               ptr_in   = '0;
               state_in = bpa_pkg::S_AREAD;
            end
         end
         bpa_pkg::S_AREAD: begin
            raddr    = ptr_ff;
            state_in = bpa_pkg::S_ACHECK;
         end
         bpa_pkg::S_ACHECK: begin
            if (rd_ff.ordp1 == k_ff + 4'd1 && !rd_ff.used) begin
               page_in  = ptr_ff;
               cnt_dec  = 1'b1;
               cnt_dsel = k_ff;
               state_in = bpa_pkg::S_ASPLIT;
            end else if (ptr_ff == 10'd1023) begin
               stat_in  = bpa_pkg::ST_NO_BLOCK;
               state_in = bpa_pkg::S_DONE;
            end else begin
               ptr_in   = ptr_ff + 10'd1;
               raddr    = ptr_ff + 10'd1;
               state_in = bpa_pkg::S_ACHECK;
            end
         end
         bpa_pkg::S_ASPLIT: begin
            we = 1'b1;
            if (k_ff > want_ff) begin
               waddr    = page_ff + (10'd1 << (k_ff - 4'd1));
               wdata    = '{used: 1'b0, ordp1: k_ff};
               cnt_inc  = 1'b1;
               cnt_isel = k_ff - 4'd1;
               k_in     = k_ff - 4'd1;
            end else begin
               waddr    = page_ff;
               wdata    = '{used: 1'b1, ordp1: want_ff + 4'd1};
               ord_in   = want_ff;
               stat_in  = bpa_pkg::ST_OK;
               state_in = bpa_pkg::S_DONE;
            end
         end
         bpa_pkg::S_FREAD: begin
            raddr    = page_ff;
            state_in = bpa_pkg::S_FCHECK;
         end
         bpa_pkg::S_FCHECK: begin
            if (rd_ff.ordp1 == 4'd0 || !rd_ff.used || rd_ff.ordp1 > 4'd11) begin
               stat_in  = bpa_pkg::ST_BAD_FREE;
               state_in = bpa_pkg::S_DONE;
            end else begin
               ord_in   = rd_ff.ordp1 - 4'd1;
               state_in = bpa_pkg::S_BREAD;
            end
         end
         bpa_pkg::S_BREAD: begin
            raddr = bud;
            if (ord_ff >= 4'd10) begin
               we       = 1'b1;
               waddr    = page_ff;
               wdata    = '{used: 1'b0, ordp1: ord_ff + 4'd1};
               cnt_inc  = 1'b1;
               cnt_isel = ord_ff;
               stat_in  = bpa_pkg::ST_OK;
               state_in = bpa_pkg::S_DONE;
            end else state_in = bpa_pkg::S_BCHECK;
         end
         bpa_pkg::S_BCHECK: begin
            we = 1'b1;
            if (rd_ff.ordp1 != ord_ff + 4'd1 || rd_ff.used) begin
               waddr    = page_ff;
               wdata    = '{used: 1'b0, ordp1: ord_ff + 4'd1};
               cnt_inc  = 1'b1;
               cnt_isel = ord_ff;
               stat_in  = bpa_pkg::ST_OK;
               state_in = bpa_pkg::S_DONE;
            end else begin
               // clear the higher head of the pair; the lower is rewritten later
               waddr    = (page_ff < bud) ? bud : page_ff;
               wdata    = '0;
               cnt_dec  = 1'b1;
               cnt_dsel = ord_ff;
               page_in  = (page_ff < bud) ? page_ff : bud;
               ord_in   = ord_ff + 4'd1;
               state_in = bpa_pkg::S_BREAD;
            end
         end
         bpa_pkg::S_DONE: begin
            state_in = bpa_pkg::S_IDLE;
         end
         default: state_in = bpa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bpa_pkg::S_CLEAR;
         ptr_ff    <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i <= 10; i++) cnt_ff[i] <= (i == 10) ? 11'd1 : 11'd0;
      end else begin
         state_ff  <= state_in;
         ptr_ff    <= ptr_in;
         strobe_ff <= (state_ff == bpa_pkg::S_DONE);
         for (int i = 0; i <= 10; i++)
            cnt_ff[i] <= cnt_ff[i]
                         - ((cnt_dec && cnt_dsel == 4'(i)) ? 11'd1 : 11'd0)
                         + ((cnt_inc && cnt_isel == 4'(i)) ? 11'd1 : 11'd0);
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      ord_ff  <= ord_in;
      k_ff    <= k_in;
      page_ff <= page_in;
      stat_ff <= stat_in;
      if (state_ff == bpa_pkg::S_DONE) begin
         rsp_ff.status <= bpa_pkg::status_type'(stat_ff);
         if (stat_ff == bpa_pkg::ST_OK) begin
            rsp_ff.block_address <= {page_ff, 12'd0};
            rsp_ff.block_order   <= ord_ff;
         end else begin
            rsp_ff.block_address <= '0;
            rsp_ff.block_order   <= '0;
         end
      end
   end

   assign busy       = (state_ff != bpa_pkg::S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // one response per accepted request
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bpa_pkg::S_DONE) |=> rsp_strobe)
      else $error("missing response");
   a_strobe_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response held two cycles");
   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status == bpa_pkg::ST_OK) |-> rsp_data.block_order <= 4'd10)
      else $error("order out of range");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int PageBytes = 4096;
   localparam int IdleLimit = 20000;
   localparam int NumPages  = bpa_pkg::NumPages;
   localparam int MaxOrder  = bpa_pkg::MaxOrder;
   localparam int PageBits  = bpa_pkg::PageBits;
   localparam int AddrW     = bpa_pkg::AddrW;
   localparam int SizeW     = bpa_pkg::SizeW;
   localparam int OrderW    = bpa_pkg::OrderW;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   bpa_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   bpa_pkg::rsp_type rsp_data;

   buddy_page_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // shadow copy of the page table and per-order free counts
   bit               page_used [NumPages];
   int               page_ordp1 [NumPages];
   int               free_cnt [MaxOrder+1];
   bpa_pkg::rsp_type pending_rsp [$];
   int               live_addr [$];
   int               errors = 0;
   int               n_beats = 0;
   int               n_rsp = 0;
   int               n_alloc_ok = 0;
   int               n_merges = 0;
   int               n_no_block = 0;
   int               n_bad = 0;
   int               idle_pct = 0;
   int               quiet_cycles = 0;

   function automatic bpa_pkg::rsp_type mk_rsp(bpa_pkg::status_type st, int addr, int ord);
      bpa_pkg::rsp_type r;
      r.status        = st;
      r.block_address = AddrW'(addr);
      r.block_order   = OrderW'(ord);
      return r;
   endfunction

   // allocate: round up to power-of-two pages, take lowest free block, split
   function automatic bpa_pkg::rsp_type predict_alloc(logic [SizeW-1:0] size);
      int pages;
      int want;
      int k;
      int found;
      int half;
      if (size[PageBits-1:0] != 0) return mk_rsp(bpa_pkg::ST_BAD_SIZE, 0, 0);
      pages = int'(size >> PageBits);
      want = 0;
      while ((1 << want) < pages) want++;
      if (want > MaxOrder) return mk_rsp(bpa_pkg::ST_NO_BLOCK, 0, 0);
      k = want;
      while (k <= MaxOrder && free_cnt[k] == 0) k++;
      if (k > MaxOrder) return mk_rsp(bpa_pkg::ST_NO_BLOCK, 0, 0);
      found = -1;
      for (int p = 0; p < NumPages; p++) begin
         if (page_ordp1[p] == k + 1 && !page_used[p]) begin
            found = p;
            break;
         end
      end
      if (found < 0) return mk_rsp(bpa_pkg::ST_NO_BLOCK, 0, 0);
      free_cnt[k]--;
      while (k > want) begin
         k--;
         half = found + (1 << k);
         if (half < NumPages) begin
            page_ordp1[half] = k + 1;
            page_used[half]  = 1'b0;
            free_cnt[k]++;
         end
      end
      page_ordp1[found] = want + 1;
      page_used[found]  = 1'b1;
      return mk_rsp(bpa_pkg::ST_OK, found * PageBytes, want);
   endfunction

   // free: release the head, then merge with free buddies upward
   function automatic bpa_pkg::rsp_type predict_free(logic [AddrW-1:0] addr);
      int p;
      int o;
      int bud;
      int lo;
      int hi;
      p = int'(addr >> PageBits);
      if (p >= NumPages) return mk_rsp(bpa_pkg::ST_BAD_FREE, 0, 0);
      if (page_ordp1[p] == 0 || !page_used[p] || page_ordp1[p] > MaxOrder + 1)
         return mk_rsp(bpa_pkg::ST_BAD_FREE, 0, 0);
      o = page_ordp1[p] - 1;
      while (o < MaxOrder) begin
         bud = p ^ (1 << o);
         if (bud + (1 << o) > NumPages) break;
         if (page_ordp1[bud] != o + 1 || page_used[bud]) break;
         free_cnt[o]--;
         lo = (p < bud) ? p : bud;
         hi = (p < bud) ? bud : p;
         page_ordp1[hi] = 0;
         page_used[hi]  = 1'b0;
         page_ordp1[lo] = 0;
         page_used[lo]  = 1'b0;
         p = lo;
         o++;
         n_merges++;
      end
      page_ordp1[p] = o + 1;
      page_used[p]  = 1'b0;
      free_cnt[o]++;
      return mk_rsp(bpa_pkg::ST_OK, p * PageBytes, o);
   endfunction

   // drive one beat, wait for it to be taken, then record the expected response
   task automatic send_req(logic mode, logic [SizeW-1:0] size, logic [AddrW-1:0] addr);
      bpa_pkg::req_type r;
      bpa_pkg::rsp_type e;
      int               a;
      r.mode         = mode;
      r.size_bytes   = size;
      r.free_address = addr;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      n_beats++;
      if (mode) begin
         e = predict_free(addr);
         if (e.status == bpa_pkg::ST_OK) begin
            for (int i = 0; i < live_addr.size(); i++) begin
               if (live_addr[i] == int'(addr >> PageBits)) begin
                  live_addr.delete(i);
                  break;
               end
            end
         end
      end else begin
         e = predict_alloc(size);
         if (e.status == bpa_pkg::ST_OK) begin
            a = int'(e.block_address >> PageBits);
            live_addr.push_back(a);
            n_alloc_ok++;
         end
      end
      if (e.status == bpa_pkg::ST_NO_BLOCK) n_no_block++;
      if (e.status == bpa_pkg::ST_BAD_SIZE || e.status == bpa_pkg::ST_BAD_FREE) n_bad++;
      pending_rsp.push_back(e);
      // sender gap, dropped in the same step the beat was taken
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // response checker and watchdog
   always @(posedge clock) begin
      bpa_pkg::rsp_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IdleLimit) begin
            $display("%0t: watchdog expired, %0d responses outstanding", $time,
                     pending_rsp.size());
            $display("tb: done, errors");
            $finish;
         end
      end
      if (!reset && rsp_strobe) begin
         n_rsp++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response %p", $time, rsp_data);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status || rsp_data.block_address !== e.block_address ||
                rsp_data.block_order !== e.block_order) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_req(1'b0, '0, '1);                   // zero size, one page
      send_req(1'b1, '1, 22'h000abc);           // unaligned free, merges to top
      send_req(1'b0, 23'h400000, '0);           // whole pool
      send_req(1'b0, 23'h001000, '0);           // pool exhausted
      send_req(1'b1, '0, 22'h3ff000);           // non-head page
      send_req(1'b1, '0, 22'h000000);
      send_req(1'b1, '0, 22'h000000);           // already free
      send_req(1'b0, 23'h401000, '0);           // rounds above top order
      send_req(1'b0, 23'h7ff000, '0);
      send_req(1'b0, 23'h7fffff, '0);           // not a page multiple
      send_req(1'b0, 23'h000001, '0);
      send_req(1'b0, 23'h000800, '0);
      send_req(1'b1, '0, 22'h3fffff);           // last page, not a head
      send_req(1'b0, 23'h003000, '0);           // three pages round to four
      send_req(1'b0, 23'h001000, '0);
      send_req(1'b0, 23'h002000, '0);
      send_req(1'b1, '0, 22'h004fff);
      send_req(1'b1, '0, 22'h000000);
      send_req(1'b1, '0, 22'h006000);           // merges back to the top
      live_addr.delete();
   endtask

   task automatic test_random(int n_items);
      int               o;
      int               pages;
      int               pick;
      logic [SizeW-1:0] size;
      logic [AddrW-1:0] addr;
      for (int i = 0; i < n_items; i++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            // noise: any field values
            send_req(1'($urandom), SizeW'($urandom), AddrW'($urandom));
         end else if (pick < 55 || live_addr.size() == 0) begin
            o = ($urandom_range(9) == 0) ? $urandom_range(MaxOrder) : $urandom_range(3);
            pages = (o == 0) ? $urandom_range(1) : $urandom_range((1 << (o - 1)) + 1, 1 << o);
            size = SizeW'(pages * PageBytes);
            send_req(1'b0, size, AddrW'($urandom));
         end else begin
            pick = $urandom_range(live_addr.size() - 1);
            addr = AddrW'(live_addr[pick] * PageBytes + $urandom_range(PageBytes - 1));
            send_req(1'b1, SizeW'($urandom), addr);
         end
      end
   endtask

   initial begin
      int wait_cycles;
      for (int p = 0; p < NumPages; p++) begin
         page_used[p]  = 1'b0;
         page_ordp1[p] = 0;
      end
      for (int o = 0; o <= MaxOrder; o++) free_cnt[o] = 0;
      page_ordp1[0]      = MaxOrder + 1;
      free_cnt[MaxOrder] = 1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 16;
      test_directed();
      test_random(530);
      idle_pct = 79;
      test_random(530);
      idle_pct = 0;
      test_random(530);
      start <= 1'b0;

      // drain, then a tail for any stray response
      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < IdleLimit) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (64) @(posedge clock);

      $display("tb: %0d beats, %0d responses; %0d allocations, %0d merges", n_beats, n_rsp,
               n_alloc_ok, n_merges);
      $display("tb: %0d out-of-blocks, %0d rejected sizes or frees", n_no_block, n_bad);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
